/* sv/scfl_pkg.sv */
// Package for the size class free list allocator.
// Holds the class, status and register codes, the chunk geometry and the
// divide-by-chunk-size constants shared by all modules. No dependencies.
package scfl_pkg;

  localparam int unsigned SMALL_CHUNK_BYTES  = 64;
  localparam int unsigned MEDIUM_CHUNK_BYTES = 128;
  localparam int unsigned LARGE_CHUNK_BYTES  = 192;
  localparam int unsigned SLOTS_PER_CLASS    = 256;

  localparam int unsigned NUM_CLASSES = 3;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CLS_W       = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  // Slot numbers, and counts or links that can also hold the empty mark.
  localparam int unsigned SLOT_W = $clog2(SLOTS_PER_CLASS);
  localparam int unsigned CNT_W  = $clog2(SLOTS_PER_CLASS + 1);

  localparam int unsigned MAX_CHUNK_BYTES =
      (SMALL_CHUNK_BYTES > MEDIUM_CHUNK_BYTES) ?
      ((SMALL_CHUNK_BYTES > LARGE_CHUNK_BYTES) ? SMALL_CHUNK_BYTES : LARGE_CHUNK_BYTES) :
      ((MEDIUM_CHUNK_BYTES > LARGE_CHUNK_BYTES) ? MEDIUM_CHUNK_BYTES : LARGE_CHUNK_BYTES);
  localparam int unsigned CHUNK_W = $clog2(MAX_CHUNK_BYTES + 1);

  // Width of an in-region byte offset, and of the reciprocal products.
  localparam int unsigned OFF_W   = $clog2(SLOTS_PER_CLASS * MAX_CHUNK_BYTES);
  localparam int unsigned RECIP_W = OFF_W + 2;
  localparam int unsigned PROD_W  = OFF_W + RECIP_W;

  // q = (x * RECIP) >> SHIFT is exact for every x below 2**OFF_W.
  localparam int unsigned SMALL_SHIFT  = OFF_W + $clog2(SMALL_CHUNK_BYTES);
  localparam int unsigned MEDIUM_SHIFT = OFF_W + $clog2(MEDIUM_CHUNK_BYTES);
  localparam int unsigned LARGE_SHIFT  = OFF_W + $clog2(LARGE_CHUNK_BYTES);
  localparam longint unsigned SMALL_RECIP =
      ((64'd1 << SMALL_SHIFT) + SMALL_CHUNK_BYTES - 1) / SMALL_CHUNK_BYTES;
  localparam longint unsigned MEDIUM_RECIP =
      ((64'd1 << MEDIUM_SHIFT) + MEDIUM_CHUNK_BYTES - 1) / MEDIUM_CHUNK_BYTES;
  localparam longint unsigned LARGE_RECIP =
      ((64'd1 << LARGE_SHIFT) + LARGE_CHUNK_BYTES - 1) / LARGE_CHUNK_BYTES;

  localparam int unsigned LINK_DEPTH = NUM_CLASSES * SLOTS_PER_CLASS;
  localparam int unsigned LINK_AW    = $clog2(LINK_DEPTH);

  localparam logic [CLS_W-1:0] CLS_SMALL  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd1;
  localparam logic [CLS_W-1:0] CLS_LARGE  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ADDRESS = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BASE  = 2'd2;

  localparam logic [ADDR_W-1:0] SMALL_BASE_RST  = 32'd0;
  localparam logic [ADDR_W-1:0] MEDIUM_BASE_RST = 32'd16384;
  localparam logic [ADDR_W-1:0] LARGE_BASE_RST  = 32'd49152;

  // Result of the address check stage for a free.
  typedef struct packed {
    logic              in_range;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  offset;
  } free_chk_t;

  function automatic logic [CHUNK_W-1:0] chunk_bytes(input logic [CLS_W-1:0] cls);
    logic [CHUNK_W-1:0] res;
    unique case (cls)
      CLS_SMALL:  res = CHUNK_W'(SMALL_CHUNK_BYTES);
      CLS_MEDIUM: res = CHUNK_W'(MEDIUM_CHUNK_BYTES);
      default:    res = CHUNK_W'(LARGE_CHUNK_BYTES);
    endcase
    return res;
  endfunction

  function automatic logic [LINK_AW-1:0] link_addr(input logic [CLS_W-1:0] cls,
                                                   input logic [SLOT_W-1:0] slot);
    return LINK_AW'(cls) * LINK_AW'(SLOTS_PER_CLASS) + LINK_AW'(slot);
  endfunction

endpackage

/* sv/scfl_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is issued. No dependencies.
module scfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/scfl_free_div.sv */
// Address check stage for a free: region offset, range test and slot number.
// The slot comes from a reciprocal multiply; depends on scfl_pkg.
module scfl_free_div (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [scfl_pkg::CLS_W-1:0]    cls_i,
  input  logic [scfl_pkg::ADDR_W-1:0]   free_address_i,
  input  logic [scfl_pkg::ADDR_W-1:0]   base_i,
  output scfl_pkg::free_chk_t           chk_o
);

  logic [scfl_pkg::ADDR_W-1:0]  offset;
  logic [scfl_pkg::ADDR_W-1:0]  limit;
  logic [scfl_pkg::OFF_W-1:0]   offset_lo;
  logic [scfl_pkg::RECIP_W-1:0] recip;
  logic [scfl_pkg::PROD_W-1:0]  prod;
  logic [scfl_pkg::SLOT_W-1:0]  quot;
  scfl_pkg::free_chk_t          chk_d;
  scfl_pkg::free_chk_t          chk_q;

  assign offset    = free_address_i - base_i;
  assign offset_lo = offset[scfl_pkg::OFF_W-1:0];

  always_comb begin
    unique case (cls_i)
      scfl_pkg::CLS_SMALL: begin
        limit = scfl_pkg::ADDR_W'(scfl_pkg::SLOTS_PER_CLASS * scfl_pkg::SMALL_CHUNK_BYTES);
        recip = scfl_pkg::RECIP_W'(scfl_pkg::SMALL_RECIP);
      end
      scfl_pkg::CLS_MEDIUM: begin
        limit = scfl_pkg::ADDR_W'(scfl_pkg::SLOTS_PER_CLASS * scfl_pkg::MEDIUM_CHUNK_BYTES);
        recip = scfl_pkg::RECIP_W'(scfl_pkg::MEDIUM_RECIP);
      end
      default: begin
        limit = scfl_pkg::ADDR_W'(scfl_pkg::SLOTS_PER_CLASS * scfl_pkg::LARGE_CHUNK_BYTES);
        recip = scfl_pkg::RECIP_W'(scfl_pkg::LARGE_RECIP);
      end
    endcase
  end

  assign prod = scfl_pkg::PROD_W'(offset_lo) * scfl_pkg::PROD_W'(recip);

  always_comb begin
    unique case (cls_i)
      scfl_pkg::CLS_SMALL:  quot = scfl_pkg::SLOT_W'(prod >> scfl_pkg::SMALL_SHIFT);
      scfl_pkg::CLS_MEDIUM: quot = scfl_pkg::SLOT_W'(prod >> scfl_pkg::MEDIUM_SHIFT);
      default:              quot = scfl_pkg::SLOT_W'(prod >> scfl_pkg::LARGE_SHIFT);
    endcase
  end

  // The slot is only meaningful when the offset lies inside the region.
  always_comb begin
    chk_d.in_range = (offset < limit);
    chk_d.slot     = quot;
    chk_d.offset   = offset_lo;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chk_q <= chk_d;
    end
  end

  assign chk_o = chk_q;

endmodule

/* sv/size_class_free_list_allocator_unit.sv */
// Top level of the size class free list allocator.
// Uses scfl_pkg, scfl_ram for the link store and scfl_free_div for frees.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | func_i, request_bytes_i, free_address_i
//  out     | output    | out_valid_o / out_stall_i | chunk_address_o, size_class_o, status_o
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// An allocate or an oversized request passes through S_ALLOC, a free through
// S_FREE1 and S_FREE2: the registered link store read serves the allocate,
// the offset divide stage adds a state on a free. One word is in work at a time.
// Reset clears the list heads to empty and the fresh counts to zero at once;
// the link store needs no clearing. A stalled result sits in the output
// register while the next word is already taken in.
module size_class_free_list_allocator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic [scfl_pkg::ADDR_W-1:0]     request_bytes_i,
  input  logic [scfl_pkg::ADDR_W-1:0]     free_address_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [scfl_pkg::ADDR_W-1:0]     chunk_address_o,
  output logic [scfl_pkg::CLS_W-1:0]      size_class_o,
  output logic [scfl_pkg::STATUS_W-1:0]   status_o,
  input  logic                            cfg_we_i,
  input  logic [scfl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scfl_pkg::ADDR_W-1:0]     cfg_wdata_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_FREE1 = 2'd2;
  localparam logic [1:0] S_FREE2 = 2'd3;

  logic [1:0] state_q, state_d;

  logic [scfl_pkg::ADDR_W-1:0] base_q  [scfl_pkg::NUM_CLASSES];
  logic [scfl_pkg::CNT_W-1:0]  heads_q [scfl_pkg::NUM_CLASSES];
  logic [scfl_pkg::CNT_W-1:0]  heads_d [scfl_pkg::NUM_CLASSES];
  logic [scfl_pkg::CNT_W-1:0]  fresh_q [scfl_pkg::NUM_CLASSES];
  logic [scfl_pkg::CNT_W-1:0]  fresh_d [scfl_pkg::NUM_CLASSES];

  // Word in work.
  logic                        func_q;
  logic [scfl_pkg::CLS_W-1:0]  cls_q;
  logic                        too_large_q;
  logic                        from_list_q;
  logic                        exhausted_q;
  logic [scfl_pkg::SLOT_W-1:0] slot_q;
  logic [scfl_pkg::ADDR_W-1:0] faddr_q;

  logic                          out_valid_q, out_valid_d;
  logic [scfl_pkg::ADDR_W-1:0]   out_addr_q, res_addr;
  logic [scfl_pkg::CLS_W-1:0]    out_cls_q, res_cls;
  logic [scfl_pkg::STATUS_W-1:0] out_status_q, res_status;

  logic                        in_acc;
  logic                        out_room;
  logic                        finish;
  logic [scfl_pkg::CLS_W-1:0]  pick_cls;
  logic                        pick_too_large;
  logic [scfl_pkg::CNT_W-1:0]  head_cur;
  logic [scfl_pkg::CNT_W-1:0]  fresh_cur;
  logic                        head_ok;

  logic                         ram_re;
  logic [scfl_pkg::LINK_AW-1:0] ram_raddr;
  logic                         ram_we;
  logic [scfl_pkg::LINK_AW-1:0] ram_waddr;
  logic [scfl_pkg::CNT_W-1:0]   ram_wdata;
  logic [scfl_pkg::CNT_W-1:0]   ram_rdata;

  scfl_pkg::free_chk_t         chk;
  logic [scfl_pkg::OFF_W-1:0]  slot_off;
  logic [scfl_pkg::OFF_W-1:0]  chk_off;
  logic                        free_ok;

  // Class pick: smallest chunk size that holds the request.
  always_comb begin
    pick_too_large = 1'b0;
    if (request_bytes_i <= scfl_pkg::ADDR_W'(scfl_pkg::SMALL_CHUNK_BYTES)) begin
      pick_cls = scfl_pkg::CLS_SMALL;
    end else if (request_bytes_i <= scfl_pkg::ADDR_W'(scfl_pkg::MEDIUM_CHUNK_BYTES)) begin
      pick_cls = scfl_pkg::CLS_MEDIUM;
    end else if (request_bytes_i <= scfl_pkg::ADDR_W'(scfl_pkg::LARGE_CHUNK_BYTES)) begin
      pick_cls = scfl_pkg::CLS_LARGE;
    end else begin
      pick_cls       = scfl_pkg::CLS_SMALL;
      pick_too_large = 1'b1;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_room   = !out_valid_q || !out_stall_i;
  assign finish     = out_room && ((state_q == S_ALLOC) || (state_q == S_FREE2));

  assign head_cur  = heads_q[pick_cls];
  assign fresh_cur = fresh_q[pick_cls];
  assign head_ok   = (head_cur < scfl_pkg::CNT_W'(scfl_pkg::SLOTS_PER_CLASS));

  // The head's successor is fetched while the word is taken in.
  assign ram_re    = in_acc && (func_i == scfl_pkg::FUNC_ALLOC) && !pick_too_large && head_ok;
  assign ram_raddr = scfl_pkg::link_addr(pick_cls, head_cur[scfl_pkg::SLOT_W-1:0]);

  scfl_ram #(
    .WIDTH (scfl_pkg::CNT_W),
    .DEPTH (scfl_pkg::LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  scfl_free_div u_free_div (
    .clk_i          (clk_i),
    .load_i         (state_q == S_FREE1),
    .cls_i          (cls_q),
    .free_address_i (faddr_q),
    .base_i         (base_q[cls_q]),
    .chk_o          (chk)
  );

  assign slot_off = scfl_pkg::OFF_W'(slot_q) * scfl_pkg::OFF_W'(scfl_pkg::chunk_bytes(cls_q));
  assign chk_off  = scfl_pkg::OFF_W'(chk.slot) * scfl_pkg::OFF_W'(scfl_pkg::chunk_bytes(cls_q));
  assign free_ok  = chk.in_range && (chk_off == chk.offset) &&
                    (scfl_pkg::CNT_W'(chk.slot) < fresh_q[cls_q]);

  assign ram_we    = finish && (state_q == S_FREE2) && free_ok;
  assign ram_waddr = scfl_pkg::link_addr(cls_q, chk.slot);
  assign ram_wdata = heads_q[cls_q];

  always_comb begin
    state_d    = state_q;
    heads_d    = heads_q;
    fresh_d    = fresh_q;
    res_addr   = '0;
    res_cls    = cls_q;
    res_status = scfl_pkg::STATUS_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if ((func_i == scfl_pkg::FUNC_FREE) && !pick_too_large) begin
            state_d = S_FREE1;
          end else begin
            state_d = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        if (too_large_q) begin
          res_status = scfl_pkg::STATUS_TOO_LARGE;
        end else if (exhausted_q) begin
          res_status = scfl_pkg::STATUS_EXHAUSTED;
        end else begin
          res_addr = base_q[cls_q] + scfl_pkg::ADDR_W'(slot_off);
          if (finish) begin
            if (from_list_q) begin
              heads_d[cls_q] = ram_rdata;
            end else begin
              fresh_d[cls_q] = fresh_q[cls_q] + scfl_pkg::CNT_W'(1);
            end
          end
        end
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      S_FREE1: begin
        state_d = S_FREE2;
      end
      S_FREE2: begin
        if (!free_ok) begin
          res_status = scfl_pkg::STATUS_BAD_ADDRESS;
        end else if (finish) begin
          heads_d[cls_q] = scfl_pkg::CNT_W'(chk.slot);
        end
        if (finish) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < scfl_pkg::NUM_CLASSES; i++) begin
        heads_q[i] <= scfl_pkg::CNT_W'(scfl_pkg::SLOTS_PER_CLASS);
        fresh_q[i] <= '0;
      end
      base_q[0] <= scfl_pkg::SMALL_BASE_RST;
      base_q[1] <= scfl_pkg::MEDIUM_BASE_RST;
      base_q[2] <= scfl_pkg::LARGE_BASE_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      heads_q     <= heads_d;
      fresh_q     <= fresh_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          scfl_pkg::CFG_SMALL_BASE:  base_q[0] <= cfg_wdata_i;
          scfl_pkg::CFG_MEDIUM_BASE: base_q[1] <= cfg_wdata_i;
          scfl_pkg::CFG_LARGE_BASE:  base_q[2] <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q      <= func_i;
      cls_q       <= pick_cls;
      too_large_q <= pick_too_large;
      from_list_q <= head_ok;
      exhausted_q <= !head_ok && (fresh_cur >= scfl_pkg::CNT_W'(scfl_pkg::SLOTS_PER_CLASS));
      slot_q      <= head_ok ? head_cur[scfl_pkg::SLOT_W-1:0] :
                               fresh_cur[scfl_pkg::SLOT_W-1:0];
      faddr_q     <= free_address_i;
    end
    if (finish) begin
      out_addr_q   <= (func_q == scfl_pkg::FUNC_FREE) ? '0 : res_addr;
      out_cls_q    <= res_cls;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chunk_address_o = out_addr_q;
  assign size_class_o    = out_cls_q;
  assign status_o        = out_status_q;

endmodule
